/* hw/rtl/tsar_pkg.sv */
// Package for the temperature average reporter: field types, calibration and
// averaging constants, and the constant-divisor helper functions.
// Depends on nothing; imported by temp_sensor_average_reporter.
`timescale 1ns / 1ps

package tsar_pkg;

   localparam int RawWidth      = 12;
   localparam int TempWidth     = 22;
   localparam int CelsiusWidth  = 12;
   localparam int TimeWidth     = 32;
   localparam int IntervalWidth = 13;
   localparam int LimitWidth    = 33;

   // Number of ADC bits that carry the conversion result.
   localparam int SampleBits = 12;
   localparam logic [RawWidth-1:0] RawMask = RawWidth'((64'd1 << SampleBits) - 64'd1);

   typedef logic signed [TempWidth-1:0]    temp_type;
   typedef logic signed [CelsiusWidth-1:0] celsius_type;
   typedef logic [TimeWidth-1:0]           time_type;
   typedef logic [LimitWidth-1:0]          limit_type;

   // Two-point calibration.
   localparam int CalRawLo = 762;
   localparam int CalRawHi = 1014;
   localparam int CalMcLo  = 30000;
   localparam int CalMcHi  = 130000;
   localparam int CalNum   = CalMcHi - CalMcLo;
   localparam int CalDen   = CalRawHi - CalRawLo;
   localparam int CalWhole = CalNum / CalDen;
   localparam int CalRem   = CalNum % CalDen;
   localparam int CalShift = 28;
   localparam longint CalRecip = ((64'sd1 <<< CalShift) + CalDen - 1) / CalDen;

   // Exponential average over fifty samples; the quotient by fifty is taken
   // as a halving followed by a reciprocal multiply for twenty-five.
   localparam int AvgDepth = 50;
   localparam int AvgKeep  = AvgDepth - 1;
   localparam int AvgShift = 30;
   localparam longint AvgRecip = ((64'sd1 <<< AvgShift) + AvgDepth / 2 - 1) / (AvgDepth / 2);

   localparam int MoveLimit = 1000;
   localparam int UsPerS    = 1000000;

   // Rounding to whole degrees; the quotient by a thousand is a shift by
   // three followed by a reciprocal multiply for one hundred and twenty-five.
   localparam int RoundHalf = 500;
   localparam int McPerC    = 1000;
   localparam int CelShift  = 25;
   localparam longint CelRecip = ((64'sd1 <<< CelShift) + McPerC / 8 - 1) / (McPerC / 8);

   function automatic temp_type calibrate(input logic [RawWidth-1:0] raw);
      logic [RawWidth-1:0]        r;
      logic signed [RawWidth:0]   d;
      logic [RawWidth-1:0]        m;
      logic [19:0]                rem_num;
      logic [40:0]                rem_prod;
      logic [20:0]                q;
      logic signed [TempWidth-1:0] qs;
      r        = raw & RawMask;
      d        = $signed({1'b0, r}) - $signed((RawWidth + 1)'(CalRawLo));
      m        = d[RawWidth] ? RawWidth'(-d) : RawWidth'(d);
      rem_num  = 20'(m) * 20'(CalRem);
      rem_prod = 41'(rem_num) * 41'(CalRecip);
      q        = 21'(m) * 21'(CalWhole) + 21'(rem_prod >> CalShift);
      qs       = $signed({1'b0, q});
      if (d[RawWidth]) begin
         return $signed(TempWidth'(CalMcLo)) - qs;
      end
      return $signed(TempWidth'(CalMcLo)) + qs;
   endfunction

   function automatic temp_type average_step(input temp_type avg, input temp_type t);
      logic signed [27:0] num;
      logic [26:0]        mag;
      logic [25:0]        half;
      logic [51:0]        prod;
      logic [21:0]        q;
      num  = $signed(28'(avg)) * $signed(28'(AvgKeep)) + $signed(28'(t));
      mag  = num[27] ? 27'(-num) : 27'(num);
      half = mag[26:1];
      prod = 52'(half) * 52'(AvgRecip);
      q    = 22'(prod >> AvgShift);
      if (num[27]) begin
         return -$signed(q);
      end
      return $signed(q);
   endfunction

   function automatic celsius_type round_celsius(input temp_type avg);
      logic signed [TempWidth:0] w;
      logic [20:0]               mag;
      logic [17:0]               x;
      logic [36:0]               prod;
      logic [CelsiusWidth-1:0]   q;
      w    = $signed((TempWidth + 1)'(avg)) + $signed((TempWidth + 1)'(RoundHalf));
      mag  = w[TempWidth] ? 21'(-w) : 21'(w);
      x    = mag[20:3];
      prod = 37'(x) * 37'(CelRecip);
      q    = CelsiusWidth'(prod >> CelShift);
      if (w[TempWidth]) begin
         return -$signed(q);
      end
      return $signed(q);
   endfunction

endpackage

/* hw/rtl/temp_sensor_average_reporter.sv */
// Temperature average reporter: calibration, running average and report decision.
// Depends on tsar_pkg for types, constants and the constant-divisor functions.
// Usage:
// Each word on the req_ channel carries a raw ADC sample, a microsecond
// timestamp and a console busy flag. Every accepted word produces exactly one
// word on the rsp_ channel: the calibrated temperature, the running average
// after this sample, a report flag and, if set, the rounded average in degrees.
// A word is taken at a clock edge where valid is high and stall is low.
// The path is three register stages (calibration, average update, rounding),
// which a sample passes through in that order. One word is accepted per clock
// while req_stall is low; the running average is updated as each sample enters
// the middle stage, which sets the one-word-per-cycle rate.
// When the receiver stalls, the result is held and the stages behind it keep
// filling until all are occupied; only then is req_stall raised.
// The user must write the report interval (csr_write_en, csr_write_data) only
// while the block is idle, which is not enforced. A synchronous reset empties
// the stages, clears the average history and sets the interval to ten seconds.
`timescale 1ns / 1ps

module temp_sensor_average_reporter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tsar_pkg::RawWidth-1:0]        req_raw_sample,
   input  logic [tsar_pkg::TimeWidth-1:0]       req_timestamp_us,
   input  logic                                 req_console_busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tsar_pkg::TempWidth-1:0]    rsp_temperature_mc,
   output logic signed [tsar_pkg::TempWidth-1:0]    rsp_average_mc,
   output logic                                 rsp_report_now,
   output logic signed [tsar_pkg::CelsiusWidth-1:0] rsp_report_celsius,
   input  logic                                 csr_write_en,
   input  logic [tsar_pkg::IntervalWidth-1:0]   csr_write_data
);

   import tsar_pkg::*;

   logic        out_ready;
   logic        u_ready;
   logic        c_ready;
   logic        u_take;

   limit_type   limit_ff;
   limit_type   limit_in;

   logic        c_valid_ff;
   temp_type    c_temp_ff;
   time_type    c_time_ff;
   logic        c_busy_ff;

   logic        u_valid_ff;
   temp_type    u_temp_ff;
   temp_type    u_avg_ff;
   logic        u_report_ff;

   logic        rsp_valid_ff;
   temp_type    rsp_temp_ff;
   temp_type    rsp_avg_ff;
   logic        rsp_report_ff;
   celsius_type rsp_celsius_ff;

   temp_type    avg_ff;
   temp_type    avg_in;
   temp_type    last_avg_ff;
   temp_type    last_avg_in;
   time_type    last_time_ff;
   time_type    last_time_in;
   logic        seeded_ff;
   logic        report_in;

   temp_type    avg_next;
   time_type    elapsed;
   logic signed [TempWidth:0] diff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign u_ready   = !u_valid_ff || out_ready;
   assign c_ready   = !c_valid_ff || u_ready;
   assign u_take    = c_valid_ff && u_ready;
   assign req_stall = !c_ready;

   assign limit_in = LimitWidth'(csr_write_data) * LimitWidth'(UsPerS);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitWidth'(10 * UsPerS);
      end else if (csr_write_en) begin
         limit_ff <= limit_in;
      end
   end

   // Calibration stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && req_valid) begin
         c_temp_ff <= calibrate(req_raw_sample);
         c_time_ff <= req_timestamp_us;
         c_busy_ff <= req_console_busy;
      end
   end

   // Average update and report decision.
   always_comb begin
      avg_next     = average_step(avg_ff, c_temp_ff);
      elapsed      = c_time_ff - last_time_ff;
      diff         = $signed((TempWidth + 1)'(avg_next)) - $signed((TempWidth + 1)'(last_avg_ff));
      avg_in       = avg_next;
      last_avg_in  = last_avg_ff;
      last_time_in = last_time_ff;
      report_in    = 1'b0;
      if (!seeded_ff) begin
         avg_in       = c_temp_ff;
         last_time_in = c_time_ff;
      end else if (limit_ff != '0 && LimitWidth'(elapsed) > limit_ff && !c_busy_ff &&
                   (diff > $signed((TempWidth + 1)'(MoveLimit)) ||
                    diff < -$signed((TempWidth + 1)'(MoveLimit)))) begin
         report_in    = 1'b1;
         last_avg_in  = avg_next;
         last_time_in = c_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff       <= '0;
         last_avg_ff  <= '0;
         last_time_ff <= '0;
         seeded_ff    <= 1'b0;
      end else if (u_take) begin
         avg_ff       <= avg_in;
         last_avg_ff  <= last_avg_in;
         last_time_ff <= last_time_in;
         seeded_ff    <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_valid_ff <= 1'b0;
      end else if (u_ready) begin
         u_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (u_take) begin
         u_temp_ff   <= c_temp_ff;
         u_avg_ff    <= avg_in;
         u_report_ff <= report_in;
      end
   end

   // Rounding and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= u_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && u_valid_ff) begin
         rsp_temp_ff    <= u_temp_ff;
         rsp_avg_ff     <= u_avg_ff;
         rsp_report_ff  <= u_report_ff;
         rsp_celsius_ff <= u_report_ff ? round_celsius(u_avg_ff) : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_temperature_mc = rsp_temp_ff;
   assign rsp_average_mc     = rsp_avg_ff;
   assign rsp_report_now     = rsp_report_ff;
   assign rsp_report_celsius = rsp_celsius_ff;

endmodule

/* tb/sv/tb_temp_sensor_average_reporter.sv */
// Self-checking testbench for temp_sensor_average_reporter: directed cases, then
// random sample streams under several report intervals, with random stalls on both sides.
// Depends on tsar_pkg and the RTL of temp_sensor_average_reporter.
`timescale 1ns / 1ps

module tb_temp_sensor_average_reporter;

   localparam int     CalLoRaw    = 762;
   localparam int     CalHiRaw    = 1014;
   localparam int     CalLoMc     = 30000;
   localparam int     CalHiMc     = 130000;
   localparam int     AvgDepth    = 50;
   localparam int     MoveLimit   = 1000;
   localparam longint UsPerSecond = 1000000;
   localparam int     RoundHalf   = 500;
   localparam int     McPerDegree = 1000;
   localparam longint SampleMask  = (64'd1 << tsar_pkg::SampleBits) - 1;
   localparam int     QuietLimit  = 2000;
   localparam int     PhaseItems  = 216;

   typedef struct {
      logic [tsar_pkg::RawWidth-1:0] raw;
      tsar_pkg::time_type            stamp;
      logic                          busy;
   } sample_type;

   typedef struct {
      tsar_pkg::temp_type    temperature;
      tsar_pkg::temp_type    average;
      logic                  report;
      tsar_pkg::celsius_type celsius;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid        = 1'b0;
   logic                                  req_stall;
   logic [tsar_pkg::RawWidth-1:0]         req_raw_sample   = '0;
   logic [tsar_pkg::TimeWidth-1:0]        req_timestamp_us = '0;
   logic                                  req_console_busy = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_stall        = 1'b0;
   logic signed [tsar_pkg::TempWidth-1:0]    rsp_temperature_mc;
   logic signed [tsar_pkg::TempWidth-1:0]    rsp_average_mc;
   logic                                  rsp_report_now;
   logic signed [tsar_pkg::CelsiusWidth-1:0] rsp_report_celsius;
   logic                                  csr_write_en     = 1'b0;
   logic [tsar_pkg::IntervalWidth-1:0]    csr_write_data   = '0;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];

   // Shadow of the block's state and its interval register.
   longint                             avg_state         = 0;
   longint                             last_report_avg   = 0;
   tsar_pkg::time_type                 last_report_stamp = '0;
   logic                               seeded_flag       = 1'b0;
   logic [tsar_pkg::IntervalWidth-1:0] interval_setting  = 13'd10;

   int                 gen_level  = 2048;
   tsar_pkg::time_type gen_stamp  = '0;
   int                 fail_count = 0;
   int                 cycle_count = 0;
   int                 quiet_cycles = 0;
   int                 hold_left = 0;
   logic               idle_allowed;

   temp_sensor_average_reporter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_sample     (req_raw_sample),
      .req_timestamp_us   (req_timestamp_us),
      .req_console_busy   (req_console_busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_temperature_mc (rsp_temperature_mc),
      .rsp_average_mc     (rsp_average_mc),
      .rsp_report_now     (rsp_report_now),
      .rsp_report_celsius (rsp_report_celsius),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Random idling is switched off for one long stretch on both sides.
   assign idle_allowed = !(cycle_count >= 1000 && cycle_count < 1800);

   function automatic reading_type predict_reading(input logic [tsar_pkg::RawWidth-1:0] raw,
                                                   input tsar_pkg::time_type stamp,
                                                   input logic busy);
      reading_type        r;
      longint             temp;
      longint             avg;
      longint             diff;
      longint             limit;
      tsar_pkg::time_type elapsed;
      temp = (longint'(CalHiMc - CalLoMc) * ((longint'(raw) & SampleMask) - CalLoRaw))
             / (CalHiRaw - CalLoRaw) + CalLoMc;
      r.temperature = tsar_pkg::temp_type'(temp);
      r.report      = 1'b0;
      r.celsius     = '0;
      if (!seeded_flag) begin
         avg_state         = temp;
         last_report_stamp = stamp;
         seeded_flag       = 1'b1;
      end else begin
         avg       = (avg_state * (AvgDepth - 1) + temp) / AvgDepth;
         elapsed   = stamp - last_report_stamp;
         limit     = longint'(interval_setting) * UsPerSecond;
         diff      = avg - last_report_avg;
         avg_state = avg;
         if (interval_setting != 0 && longint'(elapsed) > limit && !busy &&
             (diff > MoveLimit || diff < -MoveLimit)) begin
            r.report          = 1'b1;
            r.celsius         = tsar_pkg::celsius_type'((avg + RoundHalf) / McPerDegree);
            last_report_avg   = avg;
            last_report_stamp = stamp;
         end
      end
      r.average = tsar_pkg::temp_type'(avg_state);
      return r;
   endfunction

   task automatic push_sample(input int raw, input tsar_pkg::time_type stamp, input logic busy);
      sample_type s;
      s.raw   = raw[tsar_pkg::RawWidth-1:0];
      s.stamp = stamp;
      s.busy  = busy;
      pending_samples.push_back(s);
   endtask

   // Mostly a steady temperature with occasional jumps, advancing timestamps and some noise.
   task automatic queue_random_samples(input int count);
      int raw;
      int span;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 5) begin
            push_sample($urandom_range(0, 4095), $urandom(), $urandom_range(0, 1) == 1);
         end else begin
            if ($urandom_range(0, 99) < 4) begin
               gen_level = $urandom_range(0, 4095);
            end
            raw = gen_level + $urandom_range(0, 16) - 8;
            if (raw < 0) begin
               raw = 0;
            end else if (raw > 4095) begin
               raw = 4095;
            end
            if (interval_setting == 0 || interval_setting > 8) begin
               span = 3000000;
            end else begin
               span = int'(interval_setting) * 1500000;
            end
            if ($urandom_range(0, 99) < 3) begin
               gen_stamp = gen_stamp + $urandom();
            end else begin
               gen_stamp = gen_stamp + $urandom_range(0, span);
            end
            push_sample(raw, gen_stamp, $urandom_range(0, 9) == 0);
         end
      end
   endtask

   task automatic wait_until_idle();
      do begin
         @(negedge clock);
      end while (pending_samples.size() != 0 || req_valid || expected_readings.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_interval(input int value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value[tsar_pkg::IntervalWidth-1:0];
      @(posedge clock);
      csr_write_en     <= 1'b0;
      interval_setting = value[tsar_pkg::IntervalWidth-1:0];
   endtask

   initial begin
      int                 far_raw;
      tsar_pkg::time_type base;
      int                 phase_interval[8];
      phase_interval = '{1, 2, 0, 3, 10, 4294, 8191, 1};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset interval of ten seconds: seeding, the exact threshold, a busy console,
      // reports of both signs, timer wrap and the calibration points.
      push_sample(0, 32'd0, 1'b0);
      push_sample(0, 32'd10000000, 1'b0);
      push_sample(0, 32'd10000001, 1'b1);
      push_sample(0, 32'd10000001, 1'b0);
      push_sample(4095, 32'd25000000, 1'b0);
      push_sample(CalLoRaw, 32'hFFFF_FFFF, 1'b0);
      push_sample(CalHiRaw, 32'h0000_0005, 1'b0);
      push_sample(CalLoRaw - 1, 32'h0000_0006, 1'b1);
      push_sample(12'hAAA, 32'hAAAA_5555, 1'b0);
      push_sample(12'h555, 32'h5555_AAAA, 1'b1);
      push_sample(CalLoRaw + 1, 32'h5555_AAAB, 1'b0);
      push_sample(2048, 32'h6000_0000, 1'b0);
      wait_until_idle();

      // Largest legal interval: elapsed equal to the threshold, then one microsecond over it.
      write_interval(4294);
      base    = last_report_stamp;
      far_raw = (avg_state > 540000) ? 0 : 4095;
      push_sample(far_raw, base + 32'd4294000000, 1'b0);
      push_sample(far_raw, base + 32'd4294000000, 1'b0);
      push_sample(far_raw, base + 32'd4294000001, 1'b0);
      push_sample(far_raw, base + 32'd4294000001, 1'b0);
      wait_until_idle();

      // An interval beyond the legal range can never be exceeded.
      write_interval(8191);
      base    = last_report_stamp;
      far_raw = (avg_state > 540000) ? 0 : 4095;
      push_sample(far_raw, base + 32'hFFFF_FFFF, 1'b0);
      push_sample(far_raw, base + 32'hFFFF_FFFF, 1'b0);
      wait_until_idle();

      gen_stamp = last_report_stamp;
      foreach (phase_interval[p]) begin
         write_interval(phase_interval[p]);
         queue_random_samples(PhaseItems);
         wait_until_idle();
      end

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin : drive_samples
      sample_type next_sample;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_readings.push_back(
               predict_reading(req_raw_sample, req_timestamp_us, req_console_busy));
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 &&
                !(idle_allowed && $urandom_range(0, 99) < 23)) begin
               next_sample = pending_samples.pop_front();
               req_valid        <= 1'b1;
               req_raw_sample   <= next_sample.raw;
               req_timestamp_us <= next_sample.stamp;
               req_console_busy <= next_sample.busy;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The receiver holds off for two long stretches so that the pipeline fills.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (cycle_count == 700 || cycle_count == 1500) begin
         hold_left <= 60;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_allowed && ($urandom_range(0, 99) < 23);
      end
   end

   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $error("result word arrived with no expectation pending");
            fail_count++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_temperature_mc !== want.temperature) begin
               $error("temperature_mc: expected %0d, got %0d",
                      want.temperature, rsp_temperature_mc);
               fail_count++;
            end
            if (rsp_average_mc !== want.average) begin
               $error("average_mc: expected %0d, got %0d", want.average, rsp_average_mc);
               fail_count++;
            end
            if (rsp_report_now !== want.report) begin
               $error("report_now: expected %0d, got %0d", want.report, rsp_report_now);
               fail_count++;
            end
            if (rsp_report_celsius !== want.celsius) begin
               $error("report_celsius: expected %0d, got %0d",
                      want.celsius, rsp_report_celsius);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QuietLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

endmodule

/* sim.f */
hw/rtl/tsar_pkg.sv
hw/rtl/temp_sensor_average_reporter.sv
tb/sv/tb_temp_sensor_average_reporter.sv
